// ----- rtl/blm_pkg.sv -----
// shared types, constants and saturating arithmetic helpers for the line minimizer
`default_nettype none
package blm_pkg;

  localparam int unsigned FRAC_BITS  = 32;
  localparam int unsigned GOLD_SHIFT = 32;
  localparam logic signed [63:0] GOLDEN_FRACTION = 64'sd1640531527;
  localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

  // result status codes
  typedef enum logic [1:0] {
    STAT_PROBE = 2'd0,
    STAT_CONV  = 2'd1,
    STAT_LIMIT = 2'd2,
    STAT_ERR   = 2'd3
  } status_e;

  // configuration register indexes
  localparam logic [1:0] CFG_REL_TOL  = 2'd0;
  localparam logic [1:0] CFG_ABS_FLR  = 2'd1;
  localparam logic [1:0] CFG_MAX_ITER = 2'd2;

  // saturating add
  function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  // saturating subtract
  function automatic logic signed [63:0] ssub(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] sneg(input logic signed [63:0] a);
    return ssub(64'sd0, a);
  endfunction

  function automatic logic signed [63:0] sabs(input logic signed [63:0] a);
    return a[63] ? sneg(a) : a;
  endfunction

  function automatic logic signed [63:0] asr1(input logic signed [63:0] a);
    return {a[63], a[63:1]};
  endfunction

  // magnitude as unsigned, most negative value maps to 2^63
  function automatic logic [63:0] mag(input logic signed [63:0] a);
    return a[63] ? (64'd0 - a) : a;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/blm_mul.sv -----
// shared multiplier: exact 128-bit product from 32x32 partials, shift and saturate
`default_nettype none
module blm_mul (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [63:0] a_i,
  input  wire logic signed [63:0] b_i,
  input  wire logic               gold_i,
  output logic                    done_o,
  output logic signed [63:0]      res_o
);

  localparam int unsigned GOLD_SHIFT_C = blm_pkg::GOLD_SHIFT;
  localparam int unsigned FRAC_BITS_C  = blm_pkg::FRAC_BITS;

  logic [63:0]         ma_q, mb_q;
  logic                neg_q, gold_q, act_q, done_q;
  logic [2:0]          phase_q;
  logic [127:0]        acc_q;
  logic signed [63:0]  res_q;

  logic [31:0]         ah, bh;
  logic [63:0]         pp;
  logic [127:0]        ppx;
  logic [6:0]          off;
  logic signed [127:0] shd;

  // partial product for the current phase
  always_comb begin
    ah  = phase_q[1] ? ma_q[63:32] : ma_q[31:0];
    bh  = phase_q[0] ? mb_q[63:32] : mb_q[31:0];
    pp  = 64'(ah) * 64'(bh);
    off = (7'(phase_q[1]) + 7'(phase_q[0])) * 7'd32;
    ppx = {64'd0, pp} << off;
    shd = $signed(acc_q) >>> (gold_q ? GOLD_SHIFT_C : FRAC_BITS_C);
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q   <= 1'b0;
      done_q  <= 1'b0;
      phase_q <= 3'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        act_q   <= 1'b1;
        phase_q <= 3'd0;
      end else if (act_q) begin
        if (phase_q == 3'd5) begin
          act_q  <= 1'b0;
          done_q <= 1'b1;
        end
        phase_q <= phase_q + 3'd1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ma_q   <= blm_pkg::mag(a_i);
      mb_q   <= blm_pkg::mag(b_i);
      neg_q  <= a_i[63] ^ b_i[63];
      gold_q <= gold_i;
      acc_q  <= 128'd0;
    end else if (act_q) begin
      if (phase_q < 3'd4) begin
        acc_q <= acc_q + ppx;
      end else if (phase_q == 3'd4) begin
        if (neg_q) acc_q <= 128'd0 - acc_q;
      end else begin
        if ((&shd[127:63]) || !(|shd[127:63])) res_q <= shd[63:0];
        else res_q <= shd[127] ? blm_pkg::S64_MIN : blm_pkg::S64_MAX;
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
`default_nettype wire

// ----- rtl/blm_div.sv -----
// fixed-point divider: restoring, one quotient bit a cycle, truncating and saturating
`default_nettype none
module blm_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [63:0] p_i,
  input  wire logic signed [63:0] q_i,
  output logic                    done_o,
  output logic signed [63:0]      res_o
);

  logic [127:0]       num_q, quo_q;
  logic [63:0]        rem_q, m_q;
  logic               neg_q, act_q, fin_q, done_q;
  logic [6:0]         cnt_q;
  logic signed [63:0] res_q;

  logic [64:0]        rem_sh;
  logic               ge;
  logic [63:0]        lim;

  always_comb begin
    rem_sh = {rem_q, num_q[127]};
    ge     = rem_sh >= {1'b0, m_q};
    lim    = neg_q ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q  <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 7'd0;
    end else begin
      done_q <= 1'b0;
      fin_q  <= 1'b0;
      if (start_i) begin
        if (q_i == 64'sd0) done_q <= 1'b1;
        else act_q <= 1'b1;
        cnt_q <= 7'd0;
      end else if (act_q) begin
        cnt_q <= cnt_q + 7'd1;
        if (cnt_q == 7'd127) begin
          act_q <= 1'b0;
          fin_q <= 1'b1;
        end
      end else if (fin_q) begin
        done_q <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= {64'd0, blm_pkg::mag(p_i)} << blm_pkg::FRAC_BITS;
      m_q   <= blm_pkg::mag(q_i);
      neg_q <= p_i[63] ^ q_i[63];
      rem_q <= 64'd0;
      quo_q <= 128'd0;
      res_q <= p_i[63] ? blm_pkg::S64_MIN : blm_pkg::S64_MAX;
    end else if (act_q) begin
      rem_q <= ge ? 64'(rem_sh - {1'b0, m_q}) : rem_sh[63:0];
      quo_q <= {quo_q[126:0], ge};
      num_q <= {num_q[126:0], 1'b0};
    end else if (fin_q) begin
      if (quo_q[127:64] != 64'd0 || quo_q[63:0] > lim)
        res_q <= neg_q ? blm_pkg::S64_MIN : blm_pkg::S64_MAX;
      else
        res_q <= neg_q ? (64'd0 - quo_q[63:0]) : quo_q[63:0];
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
`default_nettype wire

// ----- rtl/brent_line_minimizer.sv -----
// brent line minimizer: sequencer over a shared multiplier and a serial divider
// work per input transfer: a protocol error or the iteration limit uses no unit,
// convergence one multiply, a golden step two multiplies, a parabolic fit that
// falls back to golden nine, and a parabolic step eight multiplies plus a divide;
// one item at a time, the next is taken once the result is in the output register;
// reset: async active low, block idle
`default_nettype none
module brent_line_minimizer (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [32:0]        cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               action_i,
  input  wire logic signed [63:0] bracket_a_i,
  input  wire logic signed [63:0] bracket_b_i,
  input  wire logic signed [63:0] bracket_c_i,
  input  wire logic signed [63:0] value_at_b_i,
  input  wire logic signed [63:0] probe_value_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [1:0]              status_o,
  output logic signed [63:0]      probe_point_o,
  output logic signed [63:0]      best_point_o,
  output logic signed [63:0]      best_value_o,
  output logic signed [63:0]      second_point_o,
  output logic signed [63:0]      second_value_o
);

  typedef enum logic [20:0] {
    ST_IDLE  = 21'd1 << 0,
    ST_UPD   = 21'd1 << 1,
    ST_CHK   = 21'd1 << 2,
    ST_TOL   = 21'd1 << 3,
    ST_TEST  = 21'd1 << 4,
    ST_DEC   = 21'd1 << 5,
    ST_GSEL  = 21'd1 << 6,
    ST_GOLD  = 21'd1 << 7,
    ST_MR    = 21'd1 << 8,
    ST_MQ    = 21'd1 << 9,
    ST_MT1   = 21'd1 << 10,
    ST_MT2   = 21'd1 << 11,
    ST_PQ    = 21'd1 << 12,
    ST_MHALF = 21'd1 << 13,
    ST_ML    = 21'd1 << 14,
    ST_MRR   = 21'd1 << 15,
    ST_PSEL  = 21'd1 << 16,
    ST_DIV   = 21'd1 << 17,
    ST_DCHK  = 21'd1 << 18,
    ST_FIN   = 21'd1 << 19,
    ST_OUT   = 21'd1 << 20
  } state_e;

  state_e state_q;

  // configuration
  logic [32:0] rel_q, flr_q;
  logic [9:0]  maxit_q;

  // search state
  logic signed [63:0] lo_q, hi_q, bx_q, sx_q, px_q, bf_q, sf_q, pf_q;
  logic signed [63:0] d_q, e_q, pend_q, fu_q;
  logic [9:0]         iter_q;
  logic               busy_q;

  // per-step temporaries
  logic signed [63:0] xm_q, tol1_q, tol2_q, dx_q, hw_q, r_q, q_q, t1_q, p_q;
  logic signed [63:0] half_q, ml_q, mr_q, dn_q, en_q, u_q;
  blm_pkg::status_e   res_st_q;
  logic               mwait_q, dwait_q;

  // output register
  logic               out_valid_q;
  blm_pkg::status_e   o_st_q;
  logic signed [63:0] o_probe_q, o_bp_q, o_bv_q, o_sp_q, o_sv_q;

  // shared units
  logic               mul_start, mul_gold, mul_done, div_start, div_done, is_mul;
  logic signed [63:0] mul_a, mul_b, mul_res, div_res;
  logic               in_xfer, out_free;
  logic signed [64:0] mid_sum;
  logic signed [63:0] gold_e, lim_v;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign mid_sum    = {lo_q[63], lo_q} + {hi_q[63], hi_q};
  assign gold_e     = (bx_q < xm_q) ? blm_pkg::ssub(hi_q, bx_q) : blm_pkg::ssub(lo_q, bx_q);
  assign lim_v      = blm_pkg::ssub(tol2_q, hw_q);

  // multiplier operand selection
  always_comb begin
    is_mul   = 1'b1;
    mul_gold = 1'b0;
    mul_a    = 64'sd0;
    mul_b    = 64'sd0;
    case (state_q)
      ST_TOL: begin
        mul_a = {31'd0, rel_q};
        mul_b = blm_pkg::sabs(bx_q);
      end
      ST_MR: begin
        mul_a = blm_pkg::ssub(bx_q, sx_q);
        mul_b = blm_pkg::ssub(bf_q, pf_q);
      end
      ST_MQ: begin
        mul_a = blm_pkg::ssub(bx_q, px_q);
        mul_b = blm_pkg::ssub(bf_q, sf_q);
      end
      ST_MT1: begin
        mul_a = blm_pkg::ssub(bx_q, px_q);
        mul_b = q_q;
      end
      ST_MT2: begin
        mul_a = blm_pkg::ssub(bx_q, sx_q);
        mul_b = r_q;
      end
      ST_MHALF: begin
        mul_a = q_q;
        mul_b = e_q;
      end
      ST_ML: begin
        mul_a = q_q;
        mul_b = blm_pkg::ssub(lo_q, bx_q);
      end
      ST_MRR: begin
        mul_a = q_q;
        mul_b = blm_pkg::ssub(hi_q, bx_q);
      end
      ST_GOLD: begin
        mul_a    = en_q;
        mul_b    = blm_pkg::GOLDEN_FRACTION;
        mul_gold = 1'b1;
      end
      default: is_mul = 1'b0;
    endcase
  end

  assign mul_start = is_mul && !mwait_q;
  assign div_start = (state_q == ST_DIV) && !dwait_q;

  blm_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .gold_i  (mul_gold),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  blm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .p_i     (p_q),
    .q_i     (q_q),
    .done_o  (div_done),
    .res_o   (div_res)
  );

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rel_q   <= 33'd65536;
      flr_q   <= 33'd4;
      maxit_q <= 10'd100;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        blm_pkg::CFG_REL_TOL:  rel_q   <= cfg_wdata_i;
        blm_pkg::CFG_ABS_FLR:  flr_q   <= cfg_wdata_i;
        blm_pkg::CFG_MAX_ITER: maxit_q <= cfg_wdata_i[9:0];
        default: ;
      endcase
    end
  end

  // sequencer and search state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      busy_q      <= 1'b0;
      iter_q      <= 10'd0;
      mwait_q     <= 1'b0;
      dwait_q     <= 1'b0;
      out_valid_q <= 1'b0;
      res_st_q    <= blm_pkg::STAT_PROBE;
      lo_q <= '0; hi_q <= '0; bx_q <= '0; sx_q <= '0; px_q <= '0;
      bf_q <= '0; sf_q <= '0; pf_q <= '0; d_q <= '0; e_q <= '0; pend_q <= '0;
      fu_q <= '0; xm_q <= '0; tol1_q <= '0; tol2_q <= '0; dx_q <= '0; hw_q <= '0;
      r_q <= '0; q_q <= '0; t1_q <= '0; p_q <= '0; half_q <= '0; ml_q <= '0;
      mr_q <= '0; dn_q <= '0; en_q <= '0; u_q <= '0;
    end else begin
      if (state_q == ST_OUT && out_free) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (mul_start) mwait_q <= 1'b1;
      if (div_start) dwait_q <= 1'b1;
      case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            if (!action_i) begin
              lo_q   <= (bracket_a_i < bracket_c_i) ? bracket_a_i : bracket_c_i;
              hi_q   <= (bracket_a_i > bracket_c_i) ? bracket_a_i : bracket_c_i;
              bx_q   <= bracket_b_i;
              sx_q   <= bracket_b_i;
              px_q   <= bracket_b_i;
              bf_q   <= value_at_b_i;
              sf_q   <= value_at_b_i;
              pf_q   <= value_at_b_i;
              d_q    <= 64'sd0;
              e_q    <= 64'sd0;
              iter_q <= 10'd0;
              busy_q <= 1'b1;
              state_q <= ST_CHK;
            end else if (!busy_q) begin
              res_st_q <= blm_pkg::STAT_ERR;
              state_q  <= ST_OUT;
            end else begin
              fu_q    <= probe_value_i;
              state_q <= ST_UPD;
            end
          end
        end
        // fold the delivered value into the bracket
        ST_UPD: begin
          if (fu_q <= bf_q) begin
            if (pend_q >= bx_q) lo_q <= bx_q;
            else hi_q <= bx_q;
            px_q <= sx_q;
            pf_q <= sf_q;
            sx_q <= bx_q;
            sf_q <= bf_q;
            bx_q <= pend_q;
            bf_q <= fu_q;
          end else begin
            if (pend_q < bx_q) lo_q <= pend_q;
            else hi_q <= pend_q;
            if (fu_q <= sf_q || sx_q == bx_q) begin
              px_q <= sx_q;
              pf_q <= sf_q;
              sx_q <= pend_q;
              sf_q <= fu_q;
            end else if (fu_q <= pf_q || px_q == bx_q || px_q == sx_q) begin
              px_q <= pend_q;
              pf_q <= fu_q;
            end
          end
          iter_q  <= iter_q + 10'd1;
          state_q <= ST_CHK;
        end
        ST_CHK: begin
          if (iter_q >= maxit_q) begin
            busy_q   <= 1'b0;
            res_st_q <= blm_pkg::STAT_LIMIT;
            state_q  <= ST_OUT;
          end else begin
            xm_q    <= mid_sum[64:1];
            state_q <= ST_TOL;
          end
        end
        ST_TOL: begin
          if (mul_done) begin
            mwait_q <= 1'b0;
            tol1_q  <= blm_pkg::sadd(mul_res, {31'd0, flr_q});
            state_q <= ST_TEST;
          end
        end
        ST_TEST: begin
          tol2_q  <= blm_pkg::sadd(tol1_q, tol1_q);
          dx_q    <= blm_pkg::sabs(blm_pkg::ssub(bx_q, xm_q));
          hw_q    <= blm_pkg::asr1(blm_pkg::ssub(hi_q, lo_q));
          state_q <= ST_DEC;
        end
        // convergence test, then parabolic or golden
        ST_DEC: begin
          if (dx_q <= lim_v) begin
            busy_q   <= 1'b0;
            res_st_q <= blm_pkg::STAT_CONV;
            state_q  <= ST_OUT;
          end else if (blm_pkg::sabs(e_q) > tol1_q) begin
            state_q <= ST_MR;
          end else begin
            state_q <= ST_GSEL;
          end
        end
        ST_GSEL: begin
          en_q    <= gold_e;
          state_q <= ST_GOLD;
        end
        ST_GOLD: begin
          if (mul_done) begin
            mwait_q <= 1'b0;
            dn_q    <= mul_res;
            state_q <= ST_FIN;
          end
        end
        ST_MR: begin
          if (mul_done) begin
            mwait_q <= 1'b0;
            r_q     <= mul_res;
            state_q <= ST_MQ;
          end
        end
        ST_MQ: begin
          if (mul_done) begin
            mwait_q <= 1'b0;
            q_q     <= mul_res;
            state_q <= ST_MT1;
          end
        end
        ST_MT1: begin
          if (mul_done) begin
            mwait_q <= 1'b0;
            t1_q    <= mul_res;
            state_q <= ST_MT2;
          end
        end
        ST_MT2: begin
          if (mul_done) begin
            mwait_q <= 1'b0;
            p_q     <= blm_pkg::ssub(t1_q, mul_res);
            q_q     <= blm_pkg::ssub(q_q, r_q);
            state_q <= ST_PQ;
          end
        end
        // double the denominator and fold its sign into p
        ST_PQ: begin
          if (blm_pkg::sadd(q_q, q_q) > 64'sd0) begin
            p_q <= blm_pkg::sneg(p_q);
            q_q <= blm_pkg::sadd(q_q, q_q);
          end else begin
            q_q <= blm_pkg::sneg(blm_pkg::sadd(q_q, q_q));
          end
          state_q <= ST_MHALF;
        end
        ST_MHALF: begin
          if (mul_done) begin
            mwait_q <= 1'b0;
            half_q  <= blm_pkg::asr1(mul_res);
            state_q <= ST_ML;
          end
        end
        ST_ML: begin
          if (mul_done) begin
            mwait_q <= 1'b0;
            ml_q    <= mul_res;
            state_q <= ST_MRR;
          end
        end
        ST_MRR: begin
          if (mul_done) begin
            mwait_q <= 1'b0;
            mr_q    <= mul_res;
            state_q <= ST_PSEL;
          end
        end
        ST_PSEL: begin
          if (blm_pkg::sabs(p_q) >= blm_pkg::sabs(half_q) || p_q <= ml_q || p_q >= mr_q) begin
            state_q <= ST_GSEL;
          end else begin
            en_q    <= d_q;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            dwait_q <= 1'b0;
            dn_q    <= div_res;
            u_q     <= blm_pkg::sadd(bx_q, div_res);
            state_q <= ST_DCHK;
          end
        end
        // parabolic point too close to a bracket end
        ST_DCHK: begin
          if (blm_pkg::ssub(u_q, lo_q) < tol2_q || blm_pkg::ssub(hi_q, u_q) < tol2_q)
            dn_q <= (bx_q < xm_q) ? tol1_q : blm_pkg::sneg(tol1_q);
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (blm_pkg::sabs(dn_q) >= tol1_q) begin
            pend_q <= blm_pkg::sadd(bx_q, dn_q);
            u_q    <= blm_pkg::sadd(bx_q, dn_q);
          end else begin
            pend_q <= blm_pkg::sadd(bx_q, dn_q[63] ? blm_pkg::sneg(tol1_q) : tol1_q);
            u_q    <= blm_pkg::sadd(bx_q, dn_q[63] ? blm_pkg::sneg(tol1_q) : tol1_q);
          end
          d_q      <= dn_q;
          e_q      <= en_q;
          res_st_q <= blm_pkg::STAT_PROBE;
          state_q  <= ST_OUT;
        end
        // load the output register once it is free
        ST_OUT: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (state_q == ST_OUT && out_free) begin
      o_st_q    <= res_st_q;
      o_probe_q <= (res_st_q == blm_pkg::STAT_PROBE) ? u_q : 64'sd0;
      o_bp_q    <= (res_st_q == blm_pkg::STAT_CONV) ? bx_q : 64'sd0;
      o_bv_q    <= (res_st_q == blm_pkg::STAT_CONV) ? bf_q : 64'sd0;
      o_sp_q    <= (res_st_q == blm_pkg::STAT_CONV) ? sx_q : 64'sd0;
      o_sv_q    <= (res_st_q == blm_pkg::STAT_CONV) ? sf_q : 64'sd0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = o_st_q;
  assign probe_point_o  = o_probe_q;
  assign best_point_o   = o_bp_q;
  assign best_value_o   = o_bv_q;
  assign second_point_o = o_sp_q;
  assign second_value_o = o_sv_q;

`ifndef SYNTH
  // multiplier and divider are never in flight together
  a_one_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mwait_q && dwait_q))
    else $error("multiplier and divider both pending");

  // a transfer in closes the input until the item is done
  a_in_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_ready_o)
    else $error("input still ready after transfer");

  // a probe is only issued within the evaluation budget
  a_iter_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN) |-> (iter_q < maxit_q && busy_q))
    else $error("probe issued beyond iteration limit");
`endif

endmodule
`default_nettype wire

// ----- test/brent_line_minimizer_tb.sv -----
// self-checking testbench for the brent line minimizer: random handshakes, predicted results
`default_nettype none
module brent_line_minimizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [63:0] q64_t;

  // one input transfer
  typedef struct packed {
    logic action;
    q64_t a, b, c, fb, fu;
  } search_item_t;

  // one result transfer
  typedef struct packed {
    blm_pkg::status_e status;
    q64_t probe, bx, bf, sx, sf;
  } search_result_t;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [1:0] cfg_index_i;
  logic [32:0] cfg_wdata_i;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  logic action_i;
  q64_t bracket_a_i, bracket_b_i, bracket_c_i, value_at_b_i, probe_value_i;
  logic [1:0] status_o;
  q64_t probe_point_o, best_point_o, best_value_o, second_point_o, second_value_o;

  brent_line_minimizer i_dut (.*);

  // clock
  always begin
    clk_i = 1'b1; #2;
    clk_i = 1'b0; #2;
  end

  // predictor state and configuration
  logic [32:0] m_rel, m_floor;
  logic [9:0] m_maxit, m_iter;
  q64_t m_lo, m_hi, m_x, m_w, m_v, m_fx, m_fw, m_fv, m_d, m_e, m_u;
  logic m_busy;

  search_item_t pending_q[$];
  search_result_t expected_q[$];
  int unsigned errors, n_results, n_conv, n_limit, n_err, cycles;
  int unsigned gap_in, gap_out;

  // handshake flags captured at the rising edge
  logic in_ready_o_q, out_valid_o_q;
  search_item_t sent_item;

  function automatic q64_t fx_add(q64_t a, q64_t b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? blm_pkg::S64_MIN : blm_pkg::S64_MAX;
    return s[63:0];
  endfunction

  function automatic q64_t fx_sub(q64_t a, q64_t b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? blm_pkg::S64_MIN : blm_pkg::S64_MAX;
    return s[63:0];
  endfunction

  function automatic q64_t fx_abs(q64_t a);
    return a[63] ? fx_sub(64'sd0, a) : a;
  endfunction

  // exact product shifted right with floor, saturated
  function automatic q64_t fx_mul(q64_t a, q64_t b, int sh);
    logic signed [127:0] p;
    p = (128'(a) * 128'(b)) >>> sh;
    if (p > 128'(blm_pkg::S64_MAX)) return blm_pkg::S64_MAX;
    if (p < 128'(blm_pkg::S64_MIN)) return blm_pkg::S64_MIN;
    return p[63:0];
  endfunction

  // (p << 32) / q truncated toward zero, saturated
  function automatic q64_t fx_div(q64_t p, q64_t q);
    logic signed [127:0] n, r;
    if (q == 0) return p >= 0 ? blm_pkg::S64_MAX : blm_pkg::S64_MIN;
    n = 128'(p) <<< blm_pkg::FRAC_BITS;
    r = n / 128'(q);
    if (r > 128'(blm_pkg::S64_MAX)) return blm_pkg::S64_MAX;
    if (r < 128'(blm_pkg::S64_MIN)) return blm_pkg::S64_MIN;
    return r[63:0];
  endfunction

  // one advance step of the search, returns the result it produces
  function automatic search_result_t search_advance();
    search_result_t r;
    q64_t xm, tol1, tol2, d, e, u, rr, q, p, t, old_e, half;
    r = '0;
    if (m_iter >= m_maxit) begin
      m_busy = 1'b0;
      r.status = blm_pkg::STAT_LIMIT;
      return r;
    end
    xm = (m_lo >>> 1) + (m_hi >>> 1) + q64_t'(m_lo[0] & m_hi[0]);
    tol1 = fx_add(fx_mul(q64_t'(m_rel), fx_abs(m_x), blm_pkg::FRAC_BITS), q64_t'(m_floor));
    tol2 = fx_add(tol1, tol1);
    if (fx_abs(fx_sub(m_x, xm)) <= fx_sub(tol2, fx_sub(m_hi, m_lo) >>> 1)) begin
      m_busy = 1'b0;
      r.status = blm_pkg::STAT_CONV;
      r.bx = m_x; r.bf = m_fx; r.sx = m_w; r.sf = m_fw;
      return r;
    end
    d = m_d;
    e = m_e;
    if (fx_abs(e) > tol1) begin
      rr = fx_mul(fx_sub(m_x, m_w), fx_sub(m_fx, m_fv), blm_pkg::FRAC_BITS);
      q = fx_mul(fx_sub(m_x, m_v), fx_sub(m_fx, m_fw), blm_pkg::FRAC_BITS);
      p = fx_sub(fx_mul(fx_sub(m_x, m_v), q, blm_pkg::FRAC_BITS),
                 fx_mul(fx_sub(m_x, m_w), rr, blm_pkg::FRAC_BITS));
      t = fx_sub(q, rr);
      old_e = e;
      q = fx_add(t, t);
      if (q > 0) p = fx_sub(64'sd0, p);
      else q = fx_sub(64'sd0, q);
      e = d;
      half = fx_mul(q, old_e, blm_pkg::FRAC_BITS) >>> 1;
      if (fx_abs(p) >= fx_abs(half) ||
          p <= fx_mul(q, fx_sub(m_lo, m_x), blm_pkg::FRAC_BITS) ||
          p >= fx_mul(q, fx_sub(m_hi, m_x), blm_pkg::FRAC_BITS)) begin
        e = (m_x < xm) ? fx_sub(m_hi, m_x) : fx_sub(m_lo, m_x);
        d = fx_mul(e, blm_pkg::GOLDEN_FRACTION, blm_pkg::GOLD_SHIFT);
      end else begin
        d = fx_div(p, q);
        u = fx_add(m_x, d);
        if (fx_sub(u, m_lo) < tol2 || fx_sub(m_hi, u) < tol2)
          d = (m_x < xm) ? tol1 : -tol1;
      end
    end else begin
      e = (m_x < xm) ? fx_sub(m_hi, m_x) : fx_sub(m_lo, m_x);
      d = fx_mul(e, blm_pkg::GOLDEN_FRACTION, blm_pkg::GOLD_SHIFT);
    end
    if (fx_abs(d) >= tol1) u = fx_add(m_x, d);
    else u = fx_add(m_x, (d >= 0) ? tol1 : -tol1);
    m_d = d;
    m_e = e;
    m_u = u;
    r.status = blm_pkg::STAT_PROBE;
    r.probe = u;
    return r;
  endfunction

  // update predicted state for one accepted input and queue the expected result
  function automatic void predict_search(search_item_t it);
    search_result_t r;
    if (!it.action) begin
      m_lo = (it.a < it.c) ? it.a : it.c;
      m_hi = (it.a > it.c) ? it.a : it.c;
      m_x = it.b; m_w = it.b; m_v = it.b;
      m_fx = it.fb; m_fw = it.fb; m_fv = it.fb;
      m_d = 0; m_e = 0;
      m_iter = 0;
      m_busy = 1'b1;
      r = search_advance();
    end else if (!m_busy) begin
      r = '0;
      r.status = blm_pkg::STAT_ERR;
    end else begin
      if (it.fu <= m_fx) begin
        if (m_u >= m_x) m_lo = m_x; else m_hi = m_x;
        m_v = m_w; m_fv = m_fw;
        m_w = m_x; m_fw = m_fx;
        m_x = m_u; m_fx = it.fu;
      end else begin
        if (m_u < m_x) m_lo = m_u; else m_hi = m_u;
        if (it.fu <= m_fw || m_w == m_x) begin
          m_v = m_w; m_fv = m_fw;
          m_w = m_u; m_fw = it.fu;
        end else if (it.fu <= m_fv || m_v == m_x || m_v == m_w) begin
          m_v = m_u; m_fv = it.fu;
        end
      end
      m_iter = m_iter + 10'd1;
      r = search_advance();
    end
    expected_q.push_back(r);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 45) return 0;
    if (k < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  function automatic q64_t rand64();
    return {$urandom, $urandom};
  endfunction

  // driver: presents pending items, holds them until the transfer, and throttles the output ready
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o_q) begin
        in_valid_i <= 1'b0;
      end else if (!in_valid_i) begin
        if (gap_in > 0) begin
          gap_in <= gap_in - 1;
        end else if (pending_q.size() > 0) begin
          search_item_t it;
          it = pending_q.pop_front();
          action_i <= it.action;
          bracket_a_i <= it.a;
          bracket_b_i <= it.b;
          bracket_c_i <= it.c;
          value_at_b_i <= it.fb;
          probe_value_i <= it.fu;
          in_valid_i <= 1'b1;
          gap_in <= pick_gap();
        end
      end
      if (gap_out > 0) begin
        out_ready_i <= 1'b0;
        gap_out <= gap_out - 1;
      end else begin
        out_ready_i <= 1'b1;
        if (out_valid_o_q && out_ready_i) gap_out <= pick_gap();
      end
    end
  end

  // monitor: predicts on input transfers, checks on output transfers
  always @(posedge clk_i) begin
    in_ready_o_q <= rst_ni && in_valid_i && in_ready_o;
    out_valid_o_q <= out_valid_o;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        sent_item.action = action_i;
        sent_item.a = bracket_a_i;
        sent_item.b = bracket_b_i;
        sent_item.c = bracket_c_i;
        sent_item.fb = value_at_b_i;
        sent_item.fu = probe_value_i;
        predict_search(sent_item);
      end
      if (out_valid_o && out_ready_i) begin
        search_result_t exp_r;
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result, status %0d", status_o);
        end else begin
          exp_r = expected_q.pop_front();
          n_results++;
          if (exp_r.status == blm_pkg::STAT_CONV) n_conv++;
          if (exp_r.status == blm_pkg::STAT_LIMIT) n_limit++;
          if (exp_r.status == blm_pkg::STAT_ERR) n_err++;
          if (status_o !== exp_r.status || probe_point_o !== exp_r.probe ||
              best_point_o !== exp_r.bx || best_value_o !== exp_r.bf ||
              second_point_o !== exp_r.sx || second_value_o !== exp_r.sf) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch: exp st %0d u %0d bx %0d bf %0d sx %0d sf %0d",
                       exp_r.status, exp_r.probe, exp_r.bx, exp_r.bf, exp_r.sx,
                       exp_r.sf);
              $display("          got st %0d u %0d bx %0d bf %0d sx %0d sf %0d",
                       status_o, probe_point_o, best_point_o, best_value_o,
                       second_point_o, second_value_o);
            end
          end
        end
      end
    end
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("brent_line_minimizer_tb: done, errors");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending_q.size() > 0 || in_valid_i || expected_q.size() > 0)
      @(posedge clk_i);
    repeat (250) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [32:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      blm_pkg::CFG_REL_TOL:  m_rel = val;
      blm_pkg::CFG_ABS_FLR:  m_floor = val;
      blm_pkg::CFG_MAX_ITER: m_maxit = val[9:0];
      default: ;
    endcase
  endtask

  function automatic void push_item(logic act, q64_t a, q64_t b, q64_t c, q64_t fb,
                                    q64_t fu);
    search_item_t it;
    it.action = act; it.a = a; it.b = b; it.c = c; it.fb = fb; it.fu = fu;
    pending_q.push_back(it);
  endfunction

  // one search: bracket around a center (random when wild), probe values near fb plus noise, a quarter fully random
  task automatic queue_search(int unsigned n_probes, bit wild);
    q64_t a, b, c, ctr, fb;
    int unsigned k;
    k = $urandom_range(8, 40);
    ctr = q64_t'($signed($urandom)) <<< $urandom_range(0, 20);
    a = ctr - (q64_t'($urandom_range(1, 1 << 20)) <<< k);
    c = ctr + (q64_t'($urandom_range(1, 1 << 20)) <<< k);
    b = a + ((c - a) >>> $urandom_range(1, 3));
    if (wild) begin
      a = rand64(); b = rand64(); c = rand64();
    end
    fb = q64_t'($signed($urandom)) <<< $urandom_range(0, 24);
    push_item(1'b0, a, b, c, fb, rand64());
    for (int unsigned i = 0; i < n_probes; i++) begin
      if ($urandom_range(0, 3) == 0)
        push_item(1'b1, rand64(), rand64(), rand64(), rand64(), rand64());
      else
        push_item(1'b1, rand64(), rand64(), rand64(), rand64(),
                  fb + (q64_t'($signed($urandom)) >>> $urandom_range(0, 31)) -
                  q64_t'($urandom_range(0, 1 << 30)));
    end
  endtask

  initial begin
    clk_i_init();
  end

  task automatic clk_i_init();
    int unsigned total;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_index_i = '0; cfg_wdata_i = '0;
    in_valid_i = 1'b0; out_ready_i = 1'b0; action_i = 1'b0;
    bracket_a_i = '0; bracket_b_i = '0; bracket_c_i = '0;
    value_at_b_i = '0; probe_value_i = '0;
    errors = 0; n_results = 0; n_conv = 0; n_limit = 0; n_err = 0; cycles = 0;
    gap_in = 0; gap_out = 0;
    m_rel = 33'd65536; m_floor = 33'd4; m_maxit = 10'd100; m_iter = '0;
    m_lo = 0; m_hi = 0; m_x = 0; m_w = 0; m_v = 0; m_fx = 0; m_fw = 0; m_fv = 0;
    m_d = 0; m_e = 0; m_u = 0; m_busy = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: value while idle, extremes, out-of-order and degenerate brackets
    push_item(1'b1, 0, 0, 0, 0, blm_pkg::S64_MAX);
    push_item(1'b0, -(64'sd4 <<< 32), 64'sd1 <<< 32, 64'sd8 <<< 32, 64'sd5 <<< 32, 0);
    push_item(1'b1, 0, 0, 0, 0, 64'sd1 <<< 32);
    push_item(1'b1, 0, 0, 0, 0, 64'sd9 <<< 32);
    push_item(1'b1, 0, 0, 0, 0, blm_pkg::S64_MIN);
    push_item(1'b0, blm_pkg::S64_MAX, 0, blm_pkg::S64_MIN, blm_pkg::S64_MIN, 0);
    push_item(1'b1, 0, 0, 0, 0, blm_pkg::S64_MAX);
    push_item(1'b0, 64'sd100, 64'sd50, -64'sd100, blm_pkg::S64_MAX, 0);
    push_item(1'b1, 0, 0, 0, 0, -64'sd1);
    push_item(1'b0, 0, 0, 0, 0, 0);
    push_item(1'b1, 0, 0, 0, 0, 0);
    push_item(1'b0, -64'sd1000, blm_pkg::S64_MAX, 64'sd1000, -64'sd1, -64'sd1);
    push_item(1'b1, -1, -1, -1, -1, -1);
    wait_idle();

    // zero iteration limit and extreme tolerances
    write_reg(blm_pkg::CFG_MAX_ITER, 33'd0);
    push_item(1'b0, -64'sd1 <<< 40, 64'sd3, 64'sd1 <<< 40, 64'sd7, 0);
    push_item(1'b1, 0, 0, 0, 0, 0);
    wait_idle();
    write_reg(blm_pkg::CFG_MAX_ITER, 33'd1023);
    write_reg(blm_pkg::CFG_REL_TOL, 33'd0);
    write_reg(blm_pkg::CFG_ABS_FLR, 33'd0);
    for (int i = 0; i < 4; i++) queue_search(12, 1'b0);
    wait_idle();
    write_reg(blm_pkg::CFG_REL_TOL, 33'h1_0000_0000);
    write_reg(blm_pkg::CFG_ABS_FLR, 33'h1_0000_0000);
    for (int i = 0; i < 4; i++) queue_search(6, 1'b0);
    wait_idle();

    // random phases with different settings
    total = 0;
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(blm_pkg::CFG_REL_TOL,
                (ph % 3 == 0) ? 33'd65536 : 33'($urandom_range(0, 1 << 24)));
      write_reg(blm_pkg::CFG_ABS_FLR,
                (ph == 5) ? 33'h1_FFFF_FFFF : 33'($urandom_range(0, 1 << 12)));
      write_reg(blm_pkg::CFG_MAX_ITER, (ph == 2) ? 33'd1 : 33'($urandom_range(2, 60)));
      while (total < (ph + 1) * 230) begin
        int unsigned n;
        n = $urandom_range(0, 30);
        queue_search(n, $urandom_range(0, 9) == 0);
        total += n + 1;
      end
      wait_idle();
    end

    $display("%0d results checked: %0d converged, %0d limit, %0d protocol errors",
             n_results, n_conv, n_limit, n_err);
    if (errors == 0) begin
      $display("brent_line_minimizer_tb: done, clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("brent_line_minimizer_tb: done, errors");
    end
    $finish;
  endtask

endmodule
`default_nettype wire
